FILE: hdl/hcmm_pkg.sv
// Package for the handheld console memory map: sizes, memory layouts,
// address map constants, request codes and small decode helpers.
// No dependencies; used by the top level.
package hcmm_pkg;

    // Cartridge and work RAM geometry.
    localparam int ROM_BANKS       = 2;
    localparam int WRAM_BANKS      = 8;
    localparam int WRAM_BANK_BYTES = 4096;

    localparam int ROM_BANK_BYTES = 16384;
    localparam int ROM_OFF_W      = $clog2(ROM_BANK_BYTES);
    localparam int CART_BYTES     = ROM_BANKS * ROM_BANK_BYTES;
    localparam int BOOT_BYTES     = 256;

    // ROM memory: cartridge bytes first, boot ROM right above them.
    localparam int ROM_DEPTH = CART_BYTES + BOOT_BYTES;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);

    // RAM memory: video RAM, then work RAM banks, high RAM and I/O bytes.
    localparam int VIDEO_BYTES   = 8192;
    localparam int VIDEO_AW      = $clog2(VIDEO_BYTES);
    localparam int WRAM_BYTES    = WRAM_BANKS * WRAM_BANK_BYTES;
    localparam int WRAM_BANK_W   = $clog2(WRAM_BANKS);
    localparam int WRAM_OFF_W    = $clog2(WRAM_BANK_BYTES);
    localparam int HRAM_BYTES    = 128;
    localparam int IO_BYTES      = 128;
    localparam int IO_OFF_W      = $clog2(IO_BYTES);
    localparam int RAM_WRAM_BASE = VIDEO_BYTES;
    localparam int RAM_HRAM_BASE = RAM_WRAM_BASE + WRAM_BYTES;
    localparam int RAM_IO_BASE   = RAM_HRAM_BASE + HRAM_BYTES;
    localparam int RAM_DEPTH     = RAM_IO_BASE + IO_BYTES;
    localparam int RAM_AW        = $clog2(RAM_DEPTH);

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    typedef logic [ROM_AW-1:0]      t_rom_addr;
    typedef logic [RAM_AW-1:0]      t_ram_addr;
    typedef logic [WRAM_BANK_W-1:0] t_wram_bank;
    typedef logic [CFG_IDX_W-1:0]   t_cfg_idx;
    typedef logic [IO_OFF_W-1:0]    t_io_off;

    localparam t_cfg_idx CFG_ROM_BANK  = 1'd0;
    localparam t_cfg_idx CFG_WRAM_BANK = 1'd1;

    // Bus address map.
    localparam logic [15:0] ADDR_BOOT_LAST   = 16'h00FF;
    localparam logic [15:0] ADDR_ROM_BANKED  = 16'h4000;
    localparam logic [15:0] ADDR_VIDEO       = 16'h8000;
    localparam logic [15:0] ADDR_CART_RAM    = 16'hA000;
    localparam logic [15:0] ADDR_WRAM        = 16'hC000;
    localparam logic [15:0] ADDR_WRAM_BANKED = 16'hD000;
    localparam logic [15:0] ADDR_ECHO        = 16'hE000;
    localparam logic [15:0] ADDR_ECHO_LAST   = 16'hFDFF;
    localparam logic [15:0] ADDR_IO          = 16'hFF00;
    localparam logic [15:0] ADDR_HRAM        = 16'hFF80;
    localparam logic [15:0] ADDR_IE          = 16'hFFFF;

    localparam t_io_off IO_WAVE_FIRST  = 7'h30;
    localparam t_io_off IO_WAVE_LAST   = 7'h3F;
    localparam t_io_off IO_BOOT_ENABLE = 7'h50;

    typedef enum logic [1:0] {
        FUNC_READ      = 2'd0,
        FUNC_WRITE     = 2'd1,
        FUNC_LOAD_CART = 2'd2,
        FUNC_LOAD_BOOT = 2'd3
    } t_func;

    // Where the response byte of a pending request comes from.
    typedef enum logic [1:0] {
        RSEL_ZERO,
        RSEL_ROM,
        RSEL_RAM,
        RSEL_REG
    } t_rsel;

    // Plain read/write I/O bytes; wave RAM and boot enable are handled apart.
    function automatic logic io_listed(input t_io_off off);
        logic hit;
        hit = (off <= 7'h02)
           || (off >= 7'h04 && off <= 7'h07)
           || (off == 7'h0F)
           || (off >= 7'h10 && off <= 7'h14)
           || (off >= 7'h16 && off <= 7'h1E)
           || (off >= 7'h20 && off <= 7'h26)
           || (off >= 7'h40 && off <= 7'h45);
        return hit;
    endfunction

    // Reduces a written bank number modulo the number of banks.
    function automatic t_wram_bank wram_bank_fold(input logic [CFG_DATA_W-1:0] bank);
        logic [CFG_DATA_W:0] v;
        v = {1'b0, bank};
        for (int k = 0; k < 4; k++) begin
            if (v >= (CFG_DATA_W + 1)'(WRAM_BANKS)) begin
                v = v - (CFG_DATA_W + 1)'(WRAM_BANKS);
            end
        end
        return t_wram_bank'(v);
    endfunction

endpackage

FILE: hdl/hcmm_if.sv
// Handshake channels of the memory map: the bus request and the response.
// Depends on nothing; the payload fields match the request and response bytes.
interface hcmm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, output func, output address, output write_data,
                    input ready);
    modport sink (input valid, input func, input address, input write_data,
                  output ready);
endinterface

interface hcmm_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink (input valid, input read_data, output ready);
endinterface

FILE: hdl/hcmm_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies; instantiated for the ROM and RAM stores of the memory map.
module hcmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/handheld_console_memory_map.sv
// Memory map decoder: a request is taken every cycle while the response side
// keeps up; its response goes through the pending stage (memory read), then the output register.
// Throughput is set by the single port of each memory: one access per cycle.
// Synchronous active-low reset clears the handshake state, the bank registers
// (ROM bank 1, work RAM bank 0), boot enable, interrupt enable and the I/O
// valid bits. ROM and RAM contents are not cleared; there is no clearing pass.
module handheld_console_memory_map (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hcmm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hcmm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    hcmm_req_if.sink                        i_req,
    hcmm_rsp_if.source                      o_rsp
);

    // Configuration and architectural registers.
    logic                  r_rom_bank, n_rom_bank;
    hcmm_pkg::t_wram_bank  r_wram_bank, n_wram_bank;
    logic [7:0]            r_boot_enable, n_boot_enable;
    logic [7:0]            r_ie, n_ie;
    logic [hcmm_pkg::IO_BYTES-1:0] r_io_valid, n_io_valid;

    // Pending stage (memory read in flight) and output register.
    logic            r_p_valid, n_p_valid;
    hcmm_pkg::t_rsel r_p_sel, n_p_sel;
    logic [7:0]      r_p_reg, n_p_reg;
    logic            r_o_valid, n_o_valid;
    logic [7:0]      r_o_data, n_o_data;

    logic fire, p_move;

    // Memory ports.
    logic                rom_we, rom_re, ram_we, ram_re;
    hcmm_pkg::t_rom_addr rom_addr;
    hcmm_pkg::t_ram_addr ram_addr;
    logic [7:0]          rom_rdata, ram_rdata;

    // Decode results.
    logic                  is_rd, is_wr;
    hcmm_pkg::t_func       func;
    logic [15:0]           ea;
    hcmm_pkg::t_io_off     io_off;
    hcmm_pkg::t_rsel       dec_sel;
    logic [7:0]            dec_reg;
    logic                  boot_we, ie_we, io_set;

    assign p_move      = r_p_valid && (!r_o_valid || o_rsp.ready);
    assign i_req.ready = !r_p_valid || p_move;
    assign fire        = i_req.valid && i_req.ready;

    assign o_rsp.valid     = r_o_valid;
    assign o_rsp.read_data = r_o_data;

    // Request decode and memory port drive.
    always_comb begin
        func   = hcmm_pkg::t_func'(i_req.func);
        is_rd  = fire && (func == hcmm_pkg::FUNC_READ);
        is_wr  = fire && (func == hcmm_pkg::FUNC_WRITE);
        // Echo RAM is the work RAM window 2000h lower.
        ea = i_req.address;
        if (i_req.address >= hcmm_pkg::ADDR_ECHO && i_req.address <= hcmm_pkg::ADDR_ECHO_LAST) begin
            ea = i_req.address - (hcmm_pkg::ADDR_ECHO - hcmm_pkg::ADDR_WRAM);
        end
        io_off = ea[hcmm_pkg::IO_OFF_W-1:0];

        rom_we   = 1'b0;
        rom_re   = 1'b0;
        rom_addr = '0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        ram_addr = '0;
        dec_sel  = hcmm_pkg::RSEL_ZERO;
        dec_reg  = '0;
        boot_we  = 1'b0;
        ie_we    = 1'b0;
        io_set   = 1'b0;

        unique case (func)
            hcmm_pkg::FUNC_READ, hcmm_pkg::FUNC_WRITE: begin
                if (ea <= hcmm_pkg::ADDR_BOOT_LAST) begin
                    rom_re = is_rd;
                    if (r_boot_enable != 8'd0) begin
                        rom_addr = hcmm_pkg::t_rom_addr'(hcmm_pkg::CART_BYTES)
                                 + hcmm_pkg::t_rom_addr'(ea[7:0]);
                    end else begin
                        rom_addr = hcmm_pkg::t_rom_addr'(ea[7:0]);
                    end
                end else if (ea < hcmm_pkg::ADDR_ROM_BANKED) begin
                    rom_re   = is_rd;
                    rom_addr = hcmm_pkg::t_rom_addr'(ea[hcmm_pkg::ROM_OFF_W-1:0]);
                end else if (ea < hcmm_pkg::ADDR_VIDEO) begin
                    rom_re   = is_rd;
                    rom_addr = hcmm_pkg::t_rom_addr'({r_rom_bank,
                                                      ea[hcmm_pkg::ROM_OFF_W-1:0]});
                end else if (ea < hcmm_pkg::ADDR_CART_RAM) begin
                    ram_re   = is_rd;
                    ram_we   = is_wr;
                    ram_addr = hcmm_pkg::t_ram_addr'(ea[hcmm_pkg::VIDEO_AW-1:0]);
                end else if (ea < hcmm_pkg::ADDR_WRAM) begin
                    // Cartridge RAM is not present.
                end else if (ea < hcmm_pkg::ADDR_WRAM_BANKED) begin
                    ram_re   = is_rd;
                    ram_we   = is_wr;
                    ram_addr = hcmm_pkg::t_ram_addr'(hcmm_pkg::RAM_WRAM_BASE)
                             + hcmm_pkg::t_ram_addr'(ea[hcmm_pkg::WRAM_OFF_W-1:0]);
                end else if (ea < hcmm_pkg::ADDR_ECHO) begin
                    ram_re   = is_rd;
                    ram_we   = is_wr;
                    ram_addr = hcmm_pkg::t_ram_addr'(hcmm_pkg::RAM_WRAM_BASE)
                             + hcmm_pkg::t_ram_addr'({r_wram_bank,
                                                      ea[hcmm_pkg::WRAM_OFF_W-1:0]});
                end else if (ea < hcmm_pkg::ADDR_IO) begin
                    // Object memory and the unusable area.
                end else if (ea < hcmm_pkg::ADDR_HRAM) begin
                    if (io_off == hcmm_pkg::IO_BOOT_ENABLE) begin
                        if (is_rd) begin
                            dec_sel = hcmm_pkg::RSEL_REG;
                            dec_reg = r_boot_enable;
                        end
                        boot_we = is_wr;
                    end else if ((io_off >= hcmm_pkg::IO_WAVE_FIRST
                                  && io_off <= hcmm_pkg::IO_WAVE_LAST)
                                 || hcmm_pkg::io_listed(io_off)) begin
                        // An I/O byte never written reads as its reset value, zero.
                        ram_re   = is_rd && r_io_valid[io_off];
                        ram_we   = is_wr;
                        io_set   = is_wr;
                        ram_addr = hcmm_pkg::t_ram_addr'(hcmm_pkg::RAM_IO_BASE)
                                 + hcmm_pkg::t_ram_addr'(io_off);
                    end
                end else if (ea < hcmm_pkg::ADDR_IE) begin
                    ram_re   = is_rd;
                    ram_we   = is_wr;
                    ram_addr = hcmm_pkg::t_ram_addr'(hcmm_pkg::RAM_HRAM_BASE)
                             + hcmm_pkg::t_ram_addr'(io_off);
                end else begin
                    if (is_rd) begin
                        dec_sel = hcmm_pkg::RSEL_REG;
                        dec_reg = r_ie;
                    end
                    ie_we = is_wr;
                end
                if (rom_re) begin
                    dec_sel = hcmm_pkg::RSEL_ROM;
                end else if (ram_re) begin
                    dec_sel = hcmm_pkg::RSEL_RAM;
                end
            end
            hcmm_pkg::FUNC_LOAD_CART: begin
                rom_we   = fire && ({16'd0, i_req.address} < 32'(hcmm_pkg::CART_BYTES));
                rom_addr = hcmm_pkg::t_rom_addr'(i_req.address);
            end
            hcmm_pkg::FUNC_LOAD_BOOT: begin
                rom_we   = fire && (i_req.address <= hcmm_pkg::ADDR_BOOT_LAST);
                rom_addr = hcmm_pkg::t_rom_addr'(hcmm_pkg::CART_BYTES)
                         + hcmm_pkg::t_rom_addr'(i_req.address[7:0]);
            end
        endcase
    end

    // Next state of registers, pending stage and output.
    always_comb begin
        n_rom_bank    = r_rom_bank;
        n_wram_bank   = r_wram_bank;
        n_boot_enable = r_boot_enable;
        n_ie          = r_ie;
        n_io_valid    = r_io_valid;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hcmm_pkg::CFG_ROM_BANK:  n_rom_bank  = i_cfg_data[0];
                hcmm_pkg::CFG_WRAM_BANK: n_wram_bank = hcmm_pkg::wram_bank_fold(i_cfg_data);
            endcase
        end
        if (boot_we) begin
            n_boot_enable = i_req.write_data;
        end
        if (ie_we) begin
            n_ie = i_req.write_data;
        end
        if (io_set) begin
            n_io_valid[io_off] = 1'b1;
        end

        n_p_valid = r_p_valid;
        n_p_sel   = r_p_sel;
        n_p_reg   = r_p_reg;
        if (p_move) begin
            n_p_valid = 1'b0;
        end
        if (fire) begin
            n_p_valid = 1'b1;
            n_p_sel   = dec_sel;
            n_p_reg   = dec_reg;
        end

        n_o_valid = r_o_valid;
        n_o_data  = r_o_data;
        if (p_move) begin
            n_o_valid = 1'b1;
            case (r_p_sel)
                hcmm_pkg::RSEL_ROM: n_o_data = rom_rdata;
                hcmm_pkg::RSEL_RAM: n_o_data = ram_rdata;
                hcmm_pkg::RSEL_REG: n_o_data = r_p_reg;
                default:            n_o_data = 8'd0;
            endcase
        end else if (o_rsp.ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bank    <= 1'b1;
            r_wram_bank   <= '0;
            r_boot_enable <= '0;
            r_ie          <= '0;
            r_io_valid    <= '0;
            r_p_valid     <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            r_rom_bank    <= n_rom_bank;
            r_wram_bank   <= n_wram_bank;
            r_boot_enable <= n_boot_enable;
            r_ie          <= n_ie;
            r_io_valid    <= n_io_valid;
            r_p_valid     <= n_p_valid;
            r_o_valid     <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_sel  <= n_p_sel;
        r_p_reg  <= n_p_reg;
        r_o_data <= n_o_data;
    end

    // Cartridge ROM with the boot ROM above it.
    hcmm_ram #(
        .WIDTH (8),
        .DEPTH (hcmm_pkg::ROM_DEPTH)
    ) u_rom (
        .i_clk   (i_clk),
        .i_we    (rom_we),
        .i_re    (rom_re),
        .i_addr  (rom_addr),
        .i_wdata (i_req.write_data),
        .o_rdata (rom_rdata)
    );

    // Video RAM, work RAM, high RAM and the I/O bytes.
    hcmm_ram #(
        .WIDTH (8),
        .DEPTH (hcmm_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (i_req.write_data),
        .o_rdata (ram_rdata)
    );

endmodule
